// ===== rtl/tkec_pkg.sv =====
// ----------------------------------------------------------------------------
// tkec_pkg
// shared types and constants of the touch key event controller
// ----------------------------------------------------------------------------
`default_nettype none

package tkec_pkg;

  // window length default and supported range 2..16
  localparam int AVG_LEN_DEF = 10;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // configuration register indexes
  localparam logic [7:0] CFG_MODE      = 8'd0;
  localparam logic [7:0] CFG_MIN_DELTA = 8'd1;
  localparam logic [7:0] CFG_PRESS_THR = 8'd2;
  localparam logic [7:0] CFG_HYST      = 8'd3;
  localparam logic [7:0] CFG_TICKS     = 8'd4;

  // configuration reset values
  localparam logic [1:0] MODE_RST      = 2'd0;
  localparam logic [7:0] MIN_DELTA_RST = 8'd4;
  localparam logic [4:0] PRESS_THR_RST = 5'd5;
  localparam logic [4:0] HYST_RST      = 5'd3;
  localparam logic [7:0] TICKS_RST     = 8'd3;

  // output modes
  localparam logic [1:0] MODE_PULSE      = 2'd0;
  localparam logic [1:0] MODE_LONG_PULSE = 2'd1;
  localparam logic [1:0] MODE_SELF_LATCH = 2'd2;

  // quiet readings between baseline refreshes
  localparam logic [3:0] QUIET_REFRESH = 4'hF;

  typedef enum logic [1:0] {
    EV_IDLE    = 2'd0,
    EV_PULSE   = 2'd1,
    EV_CONT    = 2'd2,
    EV_DISCARD = 2'd3
  } event_t;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] sample;
  } req_t;

  typedef struct packed {
    logic       switch_out;
    logic       touched;
    logic [1:0] event_state;
    logic [7:0] idle_level;
  } rsp_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] sample;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/tkec_front.sv =====
// ----------------------------------------------------------------------------
// tkec_front
// input stage: takes request items, classifies them and feeds the queue
// ----------------------------------------------------------------------------
`default_nettype none

module tkec_front
  import tkec_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire req_t          req,
  input  wire queue_status_t q_status,
  output logic               push,
  output cmd_t               push_cmd
);

  logic front_valid;
  cmd_t front_cmd;
  logic accept;

  assign push      = front_valid && !q_status.full;
  assign req_stall = front_valid && q_status.full;
  assign accept    = req_valid && !req_stall;
  assign push_cmd  = front_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (accept) begin
      front_valid <= 1'b1;
    end else if (push) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      front_cmd.op     <= req.req_type ? OP_TICK : OP_SAMPLE;
      front_cmd.sample <= req.sample;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tkec_queue.sv =====
// ----------------------------------------------------------------------------
// tkec_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module tkec_queue
  import tkec_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire cmd_t    push_cmd,
  input  wire logic    pop,
  output cmd_t         pop_cmd,
  output queue_status_t status
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign status.full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_cmd      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tkec_back.sv =====
// ----------------------------------------------------------------------------
// tkec_back
// execution stage: baseline window, hit counter, event machine, output reg
// ----------------------------------------------------------------------------
`default_nettype none

module tkec_back
  import tkec_pkg::*;
#(
  parameter int AVG_LEN = AVG_LEN_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_wr_en,
  input  wire logic [7:0]    cfg_index,
  input  wire logic [7:0]    cfg_wdata,
  input  wire queue_status_t q_status,
  input  wire cmd_t          pop_cmd,
  output logic               pop,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output rsp_t               rsp
);

  localparam int POS_W   = $clog2(AVG_LEN);
  localparam int WARM_W  = $clog2(AVG_LEN + 1);
  localparam int SUM_W   = $clog2(AVG_LEN * 255 + 1);
  // exact floor division by reciprocal for every sum below 2**SUM_W
  localparam int DIV_SH  = SUM_W + $clog2(AVG_LEN);
  localparam int DIV_MUL = ((1 << DIV_SH) + AVG_LEN - 1) / AVG_LEN;
  localparam int PROD_W  = SUM_W + DIV_SH + 1;

  // configuration
  logic [1:0] mode;
  logic [7:0] min_delta;
  logic [4:0] press_threshold;
  logic [4:0] hysteresis;
  logic [7:0] ticks_per_period;

  // state
  logic [7:0]        window [AVG_LEN];
  logic [POS_W-1:0]  window_pos, window_pos_next;
  logic [SUM_W-1:0]  window_sum, window_sum_next;
  logic [7:0]        baseline, baseline_next;
  logic [WARM_W-1:0] warmup_count, warmup_count_next;
  logic [6:0]        hit_count, hit_count_next;
  logic              touch_flag, touch_flag_next;
  event_t            ev_state, ev_state_next;
  logic              latch_level, latch_level_next;
  logic              out_level, out_level_next;
  logic              timer_on, timer_on_next;
  logic [7:0]        tick_count, tick_count_next;
  logic [3:0]        quiet_count, quiet_count_next;

  logic              step;
  logic              push_en;
  logic              drive_en;
  logic              drive_act;
  logic [POS_W-1:0]  pos_inc;
  logic [PROD_W-1:0] prod;
  logic [7:0]        distance;
  logic              is_touch;
  logic [5:0]        press_lvl;
  logic [6:0]        sat_lvl;
  logic              press_hit;
  logic              release_hit;
  logic [7:0]        tick_inc;
  logic [3:0]        quiet_inc;
  event_t            ev_period;

  assign step = !q_status.empty && (!rsp_valid || !rsp_stall);
  assign pop  = step;

  assign pos_inc = (window_pos == POS_W'(AVG_LEN - 1)) ? '0 : window_pos + 1'b1;

  assign distance  = (baseline >= pop_cmd.sample) ? baseline - pop_cmd.sample
                                                  : pop_cmd.sample - baseline;
  assign is_touch  = distance >= min_delta;
  assign press_lvl = {1'b0, press_threshold} + {1'b0, hysteresis};
  assign sat_lvl   = {2'b00, press_threshold} + {1'b0, press_threshold, 1'b0};
  assign press_hit = hit_count > {1'b0, press_lvl};
  // release level is negative when hysteresis exceeds threshold
  assign release_hit = (press_threshold >= hysteresis) &&
                       (({1'b0, hit_count} + {3'b000, hysteresis}) <
                        {3'b000, press_threshold});
  assign tick_inc  = tick_count + 1'b1;
  assign quiet_inc = quiet_count + 1'b1;

  // period handler outcome
  always_comb begin
    ev_period = ev_state;
    case (ev_state)
      EV_PULSE: begin
        ev_period = (touch_flag && mode == MODE_LONG_PULSE) ? EV_CONT : EV_DISCARD;
      end
      EV_DISCARD: begin
        ev_period = (touch_flag && mode != MODE_LONG_PULSE) ? EV_DISCARD : EV_IDLE;
      end
      default: ev_period = ev_state;
    endcase
  end

  always_comb begin
    warmup_count_next = warmup_count;
    hit_count_next    = hit_count;
    touch_flag_next   = touch_flag;
    ev_state_next     = ev_state;
    latch_level_next  = latch_level;
    out_level_next    = out_level;
    timer_on_next     = timer_on;
    tick_count_next   = tick_count;
    quiet_count_next  = quiet_count;
    push_en           = 1'b0;
    drive_en          = 1'b0;
    drive_act         = 1'b0;

    if (step) begin
      if (pop_cmd.op == OP_SAMPLE) begin
        if (warmup_count < WARM_W'(AVG_LEN)) begin
          warmup_count_next = warmup_count + 1'b1;
          push_en           = 1'b1;
        end else if (is_touch) begin
          if (press_hit) begin
            touch_flag_next = 1'b1;
            if (ev_state == EV_IDLE) begin
              ev_state_next   = EV_PULSE;
              drive_en        = 1'b1;
              drive_act       = 1'b1;
              timer_on_next   = 1'b1;
              tick_count_next = '0;
            end
          end
          if (hit_count < sat_lvl) begin
            hit_count_next = hit_count + 1'b1;
          end
        end else begin
          if (release_hit) begin
            touch_flag_next = 1'b0;
            if (ev_state == EV_CONT) begin
              ev_state_next   = EV_DISCARD;
              drive_en        = 1'b1;
              timer_on_next   = 1'b1;
              tick_count_next = '0;
            end
          end
          if (hit_count != '0) begin
            hit_count_next = hit_count - 1'b1;
          end else if (ev_state == EV_IDLE) begin
            if (quiet_inc == QUIET_REFRESH) begin
              push_en          = 1'b1;
              quiet_count_next = '0;
            end else begin
              quiet_count_next = quiet_inc;
            end
          end
        end
      end else if (timer_on) begin
        if (tick_inc >= ticks_per_period) begin
          ev_state_next   = ev_period;
          drive_en        = (ev_state == EV_PULSE) && (ev_period == EV_DISCARD);
          tick_count_next = '0;
          if (ev_period != EV_DISCARD) begin
            timer_on_next = 1'b0;
          end
        end else begin
          tick_count_next = tick_inc;
        end
      end
    end

    if (drive_en) begin
      if (mode == MODE_SELF_LATCH) begin
        latch_level_next = latch_level ^ drive_act;
        out_level_next   = latch_level ^ drive_act;
      end else begin
        out_level_next = drive_act;
      end
    end
  end

  // window push: running sum and baseline by reciprocal multiply
  always_comb begin
    window_pos_next = window_pos;
    window_sum_next = window_sum;
    baseline_next   = baseline;
    prod            = '0;
    if (push_en) begin
      window_pos_next = pos_inc;
      window_sum_next = window_sum - SUM_W'(window[pos_inc]) + SUM_W'(pop_cmd.sample);
      prod            = PROD_W'(window_sum_next) * PROD_W'(DIV_MUL);
      baseline_next   = 8'(prod >> DIV_SH);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_RST;
      min_delta        <= MIN_DELTA_RST;
      press_threshold  <= PRESS_THR_RST;
      hysteresis       <= HYST_RST;
      ticks_per_period <= TICKS_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MODE:      mode             <= cfg_wdata[1:0];
        CFG_MIN_DELTA: min_delta        <= cfg_wdata;
        CFG_PRESS_THR: press_threshold  <= cfg_wdata[4:0];
        CFG_HYST:      hysteresis       <= cfg_wdata[4:0];
        CFG_TICKS:     ticks_per_period <= cfg_wdata;
        default:       mode             <= mode;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < AVG_LEN; i++) begin
        window[i] <= '0;
      end
      window_pos   <= '0;
      window_sum   <= '0;
      baseline     <= '0;
      warmup_count <= '0;
      hit_count    <= '0;
      touch_flag   <= 1'b0;
      ev_state     <= EV_IDLE;
      latch_level  <= 1'b1;
      out_level    <= 1'b0;
      timer_on     <= 1'b0;
      tick_count   <= '0;
      quiet_count  <= '0;
    end else begin
      if (push_en) begin
        window[pos_inc] <= pop_cmd.sample;
      end
      window_pos   <= window_pos_next;
      window_sum   <= window_sum_next;
      baseline     <= baseline_next;
      warmup_count <= warmup_count_next;
      hit_count    <= hit_count_next;
      touch_flag   <= touch_flag_next;
      ev_state     <= ev_state_next;
      latch_level  <= latch_level_next;
      out_level    <= out_level_next;
      timer_on     <= timer_on_next;
      tick_count   <= tick_count_next;
      quiet_count  <= quiet_count_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (step) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp.switch_out  <= out_level_next;
      rsp.touched     <= touch_flag_next;
      rsp.event_state <= ev_state_next;
      rsp.idle_level  <= baseline_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/touch_key_event_controller_top.sv =====
// ----------------------------------------------------------------------------
// touch_key_event_controller_top
// capacitive touch key qualifier with event machine and switch output
// ----------------------------------------------------------------------------
// Sustained rate is one item per clock while results are not stalled: every
// sample or tick is resolved by a single back-end update via a running window
// sum and a constant reciprocal multiply for the baseline mean. Items pass
// the front register, a queue entry and the output register. The front
// register and a four-entry queue let the input keep flowing for a few items
// while the result side is stalled. The user must write configuration
// through a plain write port only while the block is idle; the block does
// not enforce this. Writes to indexes past the register list are ignored.
`default_nettype none

module touch_key_event_controller_top
  import tkec_pkg::*;
#(
  // moving-average window length, 2..16
  parameter int AVG_LEN = AVG_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  // configuration write port
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  // request channel: samples and timer ticks
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire req_t       req,
  // result channel: one item per request
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output rsp_t            rsp
);

  // front to queue
  logic          push;
  cmd_t          push_cmd;
  // queue to back
  logic          pop;
  cmd_t          pop_cmd;
  queue_status_t q_status;

  // accept and classify
  tkec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .q_status  (q_status),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // decouples input acceptance from result backpressure
  tkec_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .status   (q_status)
  );

  // baseline, hit counter, event machine and output register
  tkec_back #(
    .AVG_LEN (AVG_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_status  (q_status),
    .pop_cmd   (pop_cmd),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

// ===== bench/touch_key_event_controller_top_tb.sv =====
// ----------------------------------------------------------------------------
// touch_key_event_controller_top_tb
// self-checking bench for the touch key event controller
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the key state: the baseline
// window, hit counter, event machine and switch output. Every accepted
// request item updates that copy and queues the expected response item;
// every accepted response item is checked field by field against the oldest
// one in the queue. Stimulus is a short directed warm-up and touch sequence,
// then random touch, release, quiet, tick and noise runs under a series of
// register settings. The sender works in bursts and the receiver stalls on
// patterns of its own, with two long hold-offs that fill the block.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_key_event_controller_top_tb;
  import tkec_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 11;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS  = 130;
  localparam int HOLD_CYCLES  = 80;
  localparam int NUM_FIXED    = 8;
  localparam int NUM_RANDOM   = 2;

  // one register setting of the block
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] min_delta;
    logic [4:0] press_thr;
    logic [4:0] hyst;
    logic [7:0] period_ticks;
  } key_setting_t;

  // --------------------------------------------------------------------------
  // scoreboard: mirrors the key state and holds the expected response items
  // --------------------------------------------------------------------------
  class touch_scoreboard;
    logic [1:0] mode;
    logic [7:0] min_delta;
    logic [4:0] press_thr;
    logic [4:0] hyst;
    logic [7:0] period_ticks;

    logic [7:0] window [AVG_LEN_DEF];
    int         win_pos;
    int         win_sum;
    logic [7:0] idle_base;
    int         warmup;
    int         hits;
    bit         touch;
    event_t     ev;
    bit         latch;
    bit         out_lvl;
    bit         timer_on;
    logic [7:0] tick_cnt;
    logic [3:0] quiet;

    rsp_t expected_rsp [$];
    int   errors;

    function new();
      mode         = MODE_RST;
      min_delta    = MIN_DELTA_RST;
      press_thr    = PRESS_THR_RST;
      hyst         = HYST_RST;
      period_ticks = TICKS_RST;
      foreach (window[i]) window[i] = '0;
      win_pos   = 0;
      win_sum   = 0;
      idle_base = '0;
      warmup    = 0;
      hits      = 0;
      touch     = 1'b0;
      ev        = EV_IDLE;
      latch     = 1'b1;
      out_lvl   = 1'b0;
      timer_on  = 1'b0;
      tick_cnt  = '0;
      quiet     = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] data);
      case (idx)
        CFG_MODE:      mode = data[1:0];
        CFG_MIN_DELTA: min_delta = data;
        CFG_PRESS_THR: press_thr = data[4:0];
        CFG_HYST:      hyst = data[4:0];
        CFG_TICKS:     period_ticks = data;
        default: ;
      endcase
    endfunction

    // advance the window slot, replace it and recompute the mean
    function void shift_in(logic [7:0] v);
      win_pos = (win_pos + 1 >= AVG_LEN_DEF) ? 0 : win_pos + 1;
      win_sum = win_sum - int'(window[win_pos]) + int'(v);
      window[win_pos] = v;
      idle_base = 8'(win_sum / AVG_LEN_DEF);
    endfunction

    // self latch toggles on an active drive and holds otherwise
    function void drive_out(bit active);
      if (mode == MODE_SELF_LATCH) begin
        if (active) latch = ~latch;
        out_lvl = latch;
      end else begin
        out_lvl = active;
      end
    endfunction

    function void end_of_period();
      if (ev == EV_PULSE) begin
        if (touch && mode == MODE_LONG_PULSE) begin
          ev = EV_CONT;
        end else begin
          drive_out(1'b0);
          ev = EV_DISCARD;
        end
      end else if (ev == EV_DISCARD) begin
        if (!(touch && mode != MODE_LONG_PULSE)) ev = EV_IDLE;
      end
      if (ev != EV_DISCARD) begin
        timer_on = 1'b0;
        tick_cnt = '0;
      end
    endfunction

    function void take_sample(logic [7:0] v);
      int distance;
      int thr;
      int hy;
      if (warmup < AVG_LEN_DEF) begin
        warmup++;
        shift_in(v);
        return;
      end
      distance = int'(idle_base) - int'(v);
      if (distance < 0) distance = -distance;
      thr = int'(press_thr);
      hy  = int'(hyst);
      if (distance >= int'(min_delta)) begin
        if (hits > thr + hy) begin
          touch = 1'b1;
          if (ev == EV_IDLE) begin
            ev = EV_PULSE;
            drive_out(1'b1);
            timer_on = 1'b1;
            tick_cnt = '0;
          end
        end
        if (hits < thr * 3) hits++;
      end else begin
        // signed compare: a negative release level never releases
        if (hits < thr - hy) begin
          touch = 1'b0;
          if (ev == EV_CONT) begin
            drive_out(1'b0);
            ev = EV_DISCARD;
            timer_on = 1'b1;
            tick_cnt = '0;
          end
        end
        if (hits > 0) begin
          hits--;
        end else if (ev == EV_IDLE) begin
          quiet = quiet + 4'd1;
          if (quiet == QUIET_REFRESH) begin
            shift_in(v);
            quiet = '0;
          end
        end
      end
    endfunction

    function void take_tick();
      if (!timer_on) return;
      tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt >= period_ticks) begin
        end_of_period();
        tick_cnt = '0;
      end
    endfunction

    // returns whether the item did anything beyond being answered
    function bit note_request(req_t r);
      rsp_t want;
      bit   live;
      live = (r.req_type == OP_SAMPLE) || timer_on;
      if (r.req_type == OP_TICK) take_tick();
      else take_sample(r.sample);
      want.switch_out  = out_lvl;
      want.touched     = touch;
      want.event_state = ev;
      want.idle_level  = idle_base;
      expected_rsp.push_back(want);
      return live;
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected response item %h", $time, got);
        return;
      end
      want = expected_rsp.pop_front();
      if (got.switch_out !== want.switch_out) begin
        errors++;
        $display("%0t: switch_out expected %0d actual %0d", $time, want.switch_out,
                 got.switch_out);
      end
      if (got.touched !== want.touched) begin
        errors++;
        $display("%0t: touched expected %0d actual %0d", $time, want.touched, got.touched);
      end
      if (got.event_state !== want.event_state) begin
        errors++;
        $display("%0t: event_state expected %0d actual %0d", $time, want.event_state,
                 got.event_state);
      end
      if (got.idle_level !== want.idle_level) begin
        errors++;
        $display("%0t: idle_level expected %0d actual %0d", $time, want.idle_level,
                 got.idle_level);
      end
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic       clk;
  logic       rst       = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;
  logic       req_valid = 1'b0;
  req_t       req       = '0;
  logic       rsp_stall = 1'b0;
  logic       req_stall;
  logic       rsp_valid;
  rsp_t       rsp;

  touch_key_event_controller_top #(.AVG_LEN(AVG_LEN_DEF)) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  touch_scoreboard tracker;

  // sender burst bookkeeping and count of items that did real work
  int burst_left = 0;
  int live_items = 0;

  // raised by the stimulus, served and cleared by the result sink
  bit hold_off_req = 1'b0;

  // 2 ns clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // driving tasks
  // --------------------------------------------------------------------------

  // offer one request item and wait until the block takes it
  task automatic send_item(input req_t item);
    int gap;
    if (burst_left == 0) begin
      // a gap between bursts, often none, so some stretches run back to back
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= item;
    do @(posedge clk); while (req_stall);
    if (tracker.note_request(item)) live_items++;
    burst_left--;
  endtask

  function automatic req_t make_req(op_t op, logic [7:0] v);
    req_t r;
    r.req_type = op;
    r.sample   = v;
    return r;
  endfunction

  task automatic send_tick();
    send_item(make_req(OP_TICK, 8'($urandom)));
  endtask

  // a sample within min_delta of the current baseline (quiet reading)
  function automatic logic [7:0] near_sample();
    int lim;
    int v;
    lim = int'(tracker.min_delta) - 1;
    if (lim < 0) lim = 0;
    if (lim > 20) lim = 20;
    v = int'(tracker.idle_base) + int'($urandom_range(0, 2 * lim)) - lim;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // a sample at least min_delta away from the baseline (touch reading)
  function automatic logic [7:0] far_sample();
    int  base;
    int  md;
    int  d;
    bit  up_ok;
    bit  dn_ok;
    base  = int'(tracker.idle_base);
    md    = int'(tracker.min_delta);
    d     = md + int'($urandom_range(0, 40));
    up_ok = (base + md <= 255);
    dn_ok = (base >= md);
    if (up_ok && dn_ok) begin
      if ($urandom_range(0, 1) == 0) up_ok = 1'b0;
      else dn_ok = 1'b0;
    end
    if (up_ok) return (base + d > 255) ? 8'd255 : 8'(base + d);
    if (dn_ok) return (base - d < 0) ? 8'd0 : 8'(base - d);
    // no reading can reach the distance from here
    return 8'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // random runs
  // --------------------------------------------------------------------------

  // enough touch readings to qualify a press, sometimes cut short
  task automatic touch_run();
    int n;
    int i;
    n = int'(tracker.press_thr) + int'(tracker.hyst) + $urandom_range(1, 20);
    if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 8);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) send_tick();
      send_item(make_req(OP_SAMPLE, far_sample()));
    end
  endtask

  // enough quiet readings to drain the hit counter, sometimes cut short
  task automatic release_run();
    int n;
    int i;
    n = 3 * int'(tracker.press_thr) + $urandom_range(1, 10);
    if ($urandom_range(0, 4) == 0) n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) send_tick();
      send_item(make_req(OP_SAMPLE, near_sample()));
    end
  endtask

  // a full period of ticks while the timer runs, a few stray ones otherwise
  task automatic tick_run();
    int n;
    int i;
    if (tracker.timer_on) n = int'(tracker.period_ticks) + $urandom_range(1, 3);
    else n = $urandom_range(1, 3);
    for (i = 0; i < n; i++) send_tick();
  endtask

  // long quiet stretch so the baseline refresh kicks in
  task automatic quiet_run();
    int n;
    int i;
    n = $urandom_range(16, 40);
    for (i = 0; i < n; i++) send_item(make_req(OP_SAMPLE, near_sample()));
  endtask

  task automatic noise_run();
    int n;
    int i;
    n = $urandom_range(1, 10);
    for (i = 0; i < n; i++)
      send_item(make_req(op_t'($urandom_range(0, 1)), 8'($urandom)));
  endtask

  task automatic random_phase(input int budget);
    int start;
    int pick;
    start = live_items;
    while (live_items - start < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) touch_run();
      else if (pick < 55) release_run();
      else if (pick < 70) tick_run();
      else if (pick < 85) quiet_run();
      else noise_run();
    end
  endtask

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------

  // let every expected item come back, then the pipeline latency on top
  task automatic settle();
    @(negedge clk);
    req_valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    tracker.write_reg(idx, data);
  endtask

  task automatic apply_setting(input key_setting_t s);
    write_reg(CFG_MODE, 8'(s.mode));
    write_reg(CFG_MIN_DELTA, s.min_delta);
    write_reg(CFG_PRESS_THR, 8'(s.press_thr));
    write_reg(CFG_HYST, 8'(s.hyst));
    write_reg(CFG_TICKS, s.period_ticks);
    // an index past the register list must change nothing
    write_reg(8'($urandom_range(int'(CFG_TICKS) + 1, 255)), 8'($urandom));
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // directed part, reset settings: a stray tick, warm-up with both extremes,
  // a press that qualifies on the tenth touch reading, one period, a quiet
  // reading
  // --------------------------------------------------------------------------
  task automatic run_directed();
    int i;
    send_tick();
    send_item(make_req(OP_SAMPLE, 8'd0));
    send_item(make_req(OP_SAMPLE, 8'd255));
    for (i = 0; i < 7; i++) send_item(make_req(OP_SAMPLE, 8'd100));
    // window mean lands on 100
    send_item(make_req(OP_SAMPLE, 8'd45));
    for (i = 0; i < 10; i++) send_item(make_req(OP_SAMPLE, (i % 2 == 0) ? 8'd160 : 8'd40));
    for (i = 0; i < 3; i++) send_tick();
    send_item(make_req(OP_SAMPLE, 8'd101));
  endtask

  // settings walked through after the first phase: long pulse, self latch,
  // all-zero extremes, all-max extremes, release that never qualifies,
  // zero ticks per period, mode 3 and self latch again
  key_setting_t fixed_settings [NUM_FIXED] = '{
    '{MODE_LONG_PULSE, 8'd10,  5'd4,  5'd2,  8'd2},
    '{MODE_SELF_LATCH, 8'd6,   5'd6,  5'd1,  8'd1},
    '{2'd3,            8'd0,   5'd0,  5'd0,  8'd1},
    '{MODE_SELF_LATCH, 8'd255, 5'd31, 5'd31, 8'd255},
    '{MODE_LONG_PULSE, 8'd3,   5'd3,  5'd8,  8'd4},
    '{MODE_PULSE,      8'd20,  5'd10, 5'd0,  8'd0},
    '{2'd3,            8'd8,   5'd7,  5'd2,  8'd5},
    '{MODE_SELF_LATCH, 8'd5,   5'd2,  5'd1,  8'd3}
  };

  // --------------------------------------------------------------------------
  // main stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    key_setting_t s;
    int           p;
    tracker = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    run_directed();
    random_phase(PHASE_ITEMS);

    for (p = 0; p < NUM_FIXED + NUM_RANDOM; p++) begin
      settle();
      if (p < NUM_FIXED) begin
        s = fixed_settings[p];
      end else begin
        s.mode         = 2'($urandom_range(0, 3));
        s.min_delta    = 8'($urandom_range(0, 40));
        s.press_thr    = 5'($urandom_range(0, 31));
        s.hyst         = 5'($urandom_range(0, 31));
        s.period_ticks = 8'($urandom_range(1, 8));
      end
      apply_setting(s);
      // long receiver hold-offs while the sender keeps offering items
      if (p == 0 || p == 5) hold_off_req = 1'b1;
      random_phase(PHASE_ITEMS);
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("touch_key_event_controller_top: match");
    end else begin
      $display("touch_key_event_controller_top: mismatch");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // result sink: stall patterns in segments, long hold-off when requested
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int kind;
    int seg;
    int per;
    int i;
    forever begin
      if (hold_off_req) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          rsp_stall <= 1'b1;
        end
        hold_off_req = 1'b0;
      end
      kind = $urandom_range(0, 3);
      seg  = $urandom_range(10, 120);
      per  = $urandom_range(2, 6);
      for (i = 0; i < seg; i++) begin
        @(negedge clk);
        case (kind)
          0:       rsp_stall <= 1'b0;
          1:       rsp_stall <= 1'($urandom_range(0, 1));
          2:       rsp_stall <= ($urandom_range(0, 7) != 0);
          default: rsp_stall <= (i % per == 0);
        endcase
      end
    end
  end

  // response monitor
  initial begin : rsp_monitor
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && !rsp_stall) tracker.check_response(rsp);
    end
  end

  // overall cycle limit
  initial begin : cycle_guard
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("touch_key_event_controller_top: mismatch");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/tkec_pkg.sv
rtl/tkec_front.sv
rtl/tkec_queue.sv
rtl/tkec_back.sv
rtl/touch_key_event_controller_top.sv
bench/touch_key_event_controller_top_tb.sv
